### design/slu_pkg.sv
// shared types and codes for the serial line unit register block
// no dependencies; imported by the register block, its checker and the testbench

package slu_pkg;

  // action codes carried by an input beat
  localparam logic [1:0] ACT_POLL  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // register byte offsets
  localparam logic [2:0] OFF_RX_CSR = 3'd0;
  localparam logic [2:0] OFF_RX_BUF = 3'd2;
  localparam logic [2:0] OFF_TX_CSR = 3'd4;
  localparam logic [2:0] OFF_TX_BUF = 3'd6;

  // status bits and masks
  localparam int unsigned DONE_POS   = 7;
  localparam int unsigned ENABLE_POS = 6;
  localparam logic [15:0] DONE_MASK  = 16'h0080;
  localparam logic [15:0] TX_CSR_RST = 16'h0080;
  localparam logic [6:0]  CHAR_MASK  = 7'h7f;

  // one-shot transmit interrupt phase codes
  localparam logic [1:0] PH_OFF       = 2'd0;
  localparam logic [1:0] PH_DUE       = 2'd1;
  localparam logic [1:0] PH_DELIVERED = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_offset;
    logic [15:0] write_data;
    logic        rx_valid;
    logic [7:0]  rx_char;
  } slu_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        bus_error;
    logic        tx_valid;
    logic [6:0]  tx_char;
    logic        rx_irq;
    logic        tx_irq;
  } slu_out_t;

  // status write keeps the done bit, takes the rest from the data
  function automatic logic [15:0] keep_done(input logic [15:0] old_v, input logic [15:0] new_v);
    keep_done = (old_v & DONE_MASK) | (new_v & ~DONE_MASK);
  endfunction

endpackage

### design/slu_in_if.sv
// input channel of the serial line unit: valid/ready plus one access or tick
// no dependencies

interface slu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  reg_offset;
  logic [15:0] write_data;
  logic        rx_valid;
  logic [7:0]  rx_char;

  modport source (output valid, action, reg_offset, write_data, rx_valid, rx_char,
                  input ready);
  modport sink   (input valid, action, reg_offset, write_data, rx_valid, rx_char,
                  output ready);
endinterface

### design/slu_out_if.sv
// result channel of the serial line unit: valid/ready plus one result beat
// no dependencies

interface slu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        bus_error;
  logic        tx_valid;
  logic [6:0]  tx_char;
  logic        rx_irq;
  logic        tx_irq;

  modport source (output valid, read_data, bus_error, tx_valid, tx_char, rx_irq, tx_irq,
                  input ready);
  modport sink   (input valid, read_data, bus_error, tx_valid, tx_char, rx_irq, tx_irq,
                  output ready);
endinterface

### design/serial_line_unit_registers.sv
// serial line unit register block: four registers, poll ticks, interrupt pulses
// depends on slu_pkg, slu_in_if and slu_out_if
//
// usage:
//   in_i  takes one beat per cycle when ready: a poll tick, a register read
//         or write (byte offsets 0, 2, 4, 6; odd offsets give a bus error)
//   out_o gives exactly one result beat per input beat, in order: read data,
//         bus error, the character sent to the line and interrupt pulses
// timing:
//   an input beat is held in the input register, then all its work is done in
//   one pass of logic into the result register, which offers it; throughput
//   is one beat per cycle while out_o.ready stays high
// reset:
//   rst_ni (async, active low) empties both stages, clears rx status, rx data,
//   tx data and the one-shot phase, and sets tx status to transmitter ready
// stalls:
//   while out_o.ready is low the result register holds; one more beat is taken
//   into the input register, then in_i.ready drops until the result is taken

module serial_line_unit_registers
  import slu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  slu_in_if.sink    in_i,
  slu_out_if.source out_o
);

  // pipeline stages
  logic     in_vld_q;
  slu_in_t  in_q;
  logic     out_vld_q;
  slu_out_t out_q;
  logic     advance;

  // register state
  logic [15:0] rx_status_q, rx_status_d;
  logic [15:0] tx_status_q, tx_status_d;
  logic [6:0]  rx_data_q, rx_data_d;
  logic [7:0]  tx_data_q, tx_data_d;
  logic [1:0]  phase_q, phase_d;
  slu_out_t    res_d;

  // the item in the input register moves on when the result register is free
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.action     <= in_i.action;
      in_q.reg_offset <= in_i.reg_offset;
      in_q.write_data <= in_i.write_data;
      in_q.rx_valid   <= in_i.rx_valid;
      in_q.rx_char    <= in_i.rx_char;
    end
  end

  // one pass of the register model per beat
  always_comb begin
    rx_status_d = rx_status_q;
    tx_status_d = tx_status_q;
    rx_data_d   = rx_data_q;
    tx_data_d   = tx_data_q;
    phase_d     = phase_q;
    res_d       = '0;
    case (in_q.action)
      ACT_POLL: begin
        // take a received character only when the buffer is free
        if (!rx_status_q[DONE_POS] && in_q.rx_valid) begin
          rx_data_d             = in_q.rx_char[6:0] & CHAR_MASK;
          rx_status_d[DONE_POS] = 1'b1;
          res_d.rx_irq          = rx_status_q[ENABLE_POS];
        end
        // finish a pending transmit, else deliver a due one-shot interrupt
        if (tx_data_q != 8'd0) begin
          tx_status_d[DONE_POS] = 1'b1;
          tx_data_d             = 8'd0;
          res_d.tx_irq          = tx_status_q[ENABLE_POS];
        end else if (phase_q == PH_DUE) begin
          res_d.tx_irq = 1'b1;
          phase_d      = PH_DELIVERED;
        end
      end
      ACT_READ, ACT_WRITE: begin
        if (in_q.reg_offset[0]) begin
          res_d.bus_error = 1'b1;
        end else if (in_q.action == ACT_READ) begin
          case (in_q.reg_offset)
            OFF_RX_CSR: res_d.read_data = rx_status_q;
            OFF_RX_BUF: begin
              // reading the buffer clears receiver done
              rx_status_d[DONE_POS] = 1'b0;
              res_d.read_data       = {9'd0, rx_data_q};
            end
            OFF_TX_CSR: res_d.read_data = tx_status_q;
            default:    res_d.read_data = {8'd0, tx_data_q};
          endcase
        end else begin
          case (in_q.reg_offset)
            OFF_RX_CSR: rx_status_d = keep_done(rx_status_q, in_q.write_data);
            OFF_RX_BUF: ;
            OFF_TX_CSR: begin
              tx_status_d = keep_done(tx_status_q, in_q.write_data);
              // arm the one-shot when enabled while idle; after delivery, go back to off
              if (tx_status_d[DONE_POS] && tx_status_d[ENABLE_POS] && phase_q == PH_OFF) begin
                phase_d = PH_DUE;
              end else if (phase_q == PH_DELIVERED) begin
                phase_d = PH_OFF;
              end
            end
            default: begin
              // character goes to the line now; bit 7 marks it pending
              res_d.tx_valid        = 1'b1;
              res_d.tx_char         = in_q.write_data[6:0] & CHAR_MASK;
              tx_data_d             = {1'b1, in_q.write_data[6:0] & CHAR_MASK};
              tx_status_d[DONE_POS] = 1'b0;
              phase_d               = PH_OFF;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_status_q <= '0;
      tx_status_q <= TX_CSR_RST;
      rx_data_q   <= '0;
      tx_data_q   <= '0;
      phase_q     <= PH_OFF;
    end else if (advance) begin
      rx_status_q <= rx_status_d;
      tx_status_q <= tx_status_d;
      rx_data_q   <= rx_data_d;
      tx_data_q   <= tx_data_d;
      phase_q     <= phase_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.read_data = out_q.read_data;
  assign out_o.bus_error = out_q.bus_error;
  assign out_o.tx_valid  = out_q.tx_valid;
  assign out_o.tx_char   = out_q.tx_char;
  assign out_o.rx_irq    = out_q.rx_irq;
  assign out_o.tx_irq    = out_q.tx_irq;

endmodule

### tb/sv/serial_line_unit_registers_checker.sv
// checker for the serial line unit: predicts each result beat and compares it
// depends on slu_pkg, slu_in_if and slu_out_if

module serial_line_unit_registers_checker
  import slu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  slu_in_if           in_beat_i,
  slu_out_if          out_beat_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  // predicted register state
  logic [15:0] rx_csr;
  logic [15:0] tx_csr;
  logic [6:0]  rx_buf;
  logic [7:0]  tx_buf;
  logic [1:0]  irq_phase;

  slu_out_t pending_results [$];
  slu_in_t  access_beat;
  slu_out_t seen_result;
  slu_out_t want_result;

  // apply one access or tick to the predicted registers, return its result
  function automatic slu_out_t step_line_unit(input slu_in_t b);
    slu_out_t r;
    r = '0;
    case (b.action)
      ACT_POLL: begin
        if (!rx_csr[DONE_POS] && b.rx_valid) begin
          rx_buf = b.rx_char[6:0];
          rx_csr[DONE_POS] = 1'b1;
          r.rx_irq = rx_csr[ENABLE_POS];
        end
        if (tx_buf != 8'd0) begin
          tx_csr[DONE_POS] = 1'b1;
          tx_buf = 8'd0;
          r.tx_irq = tx_csr[ENABLE_POS];
        end else if (irq_phase == PH_DUE) begin
          r.tx_irq = 1'b1;
          irq_phase = PH_DELIVERED;
        end
      end
      ACT_READ, ACT_WRITE: begin
        if (b.reg_offset[0]) begin
          r.bus_error = 1'b1;
        end else if (b.action == ACT_READ) begin
          case (b.reg_offset)
            OFF_RX_CSR: r.read_data = rx_csr;
            OFF_RX_BUF: begin
              rx_csr[DONE_POS] = 1'b0;
              r.read_data = {9'd0, rx_buf};
            end
            OFF_TX_CSR: r.read_data = tx_csr;
            default:    r.read_data = {8'd0, tx_buf};
          endcase
        end else begin
          case (b.reg_offset)
            OFF_RX_CSR: rx_csr = {b.write_data[15:8], rx_csr[DONE_POS], b.write_data[6:0]};
            OFF_RX_BUF: ;
            OFF_TX_CSR: begin
              tx_csr = {b.write_data[15:8], tx_csr[DONE_POS], b.write_data[6:0]};
              if (tx_csr[DONE_POS] && tx_csr[ENABLE_POS] && irq_phase == PH_OFF)
                irq_phase = PH_DUE;
              if (irq_phase == PH_DELIVERED)
                irq_phase = PH_OFF;
            end
            default: begin
              r.tx_valid = 1'b1;
              r.tx_char = b.write_data[6:0];
              tx_buf = {1'b1, b.write_data[6:0]};
              tx_csr[DONE_POS] = 1'b0;
              irq_phase = PH_OFF;
            end
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_csr = '0;
      tx_csr = TX_CSR_RST;
      rx_buf = '0;
      tx_buf = '0;
      irq_phase = PH_OFF;
      pending_results.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (in_beat_i.valid && in_beat_i.ready) begin
        access_beat.action     = in_beat_i.action;
        access_beat.reg_offset = in_beat_i.reg_offset;
        access_beat.write_data = in_beat_i.write_data;
        access_beat.rx_valid   = in_beat_i.rx_valid;
        access_beat.rx_char    = in_beat_i.rx_char;
        pending_results.push_back(step_line_unit(access_beat));
      end
      if (out_beat_i.valid && out_beat_i.ready) begin
        seen_result.read_data = out_beat_i.read_data;
        seen_result.bus_error = out_beat_i.bus_error;
        seen_result.tx_valid  = out_beat_i.tx_valid;
        seen_result.tx_char   = out_beat_i.tx_char;
        seen_result.rx_irq    = out_beat_i.rx_irq;
        seen_result.tx_irq    = out_beat_i.tx_irq;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat expected none actual %h", $time, seen_result);
          mismatches_o++;
        end else begin
          want_result = pending_results.pop_front();
          check_field("read_data", want_result.read_data, seen_result.read_data);
          check_field("bus_error", want_result.bus_error, seen_result.bus_error);
          check_field("tx_valid",  want_result.tx_valid,  seen_result.tx_valid);
          check_field("tx_char",   want_result.tx_char,   seen_result.tx_char);
          check_field("rx_irq",    want_result.rx_irq,    seen_result.rx_irq);
          check_field("tx_irq",    want_result.tx_irq,    seen_result.tx_irq);
        end
      end
      outstanding_o = pending_results.size();
    end
  end

endmodule

### tb/sv/serial_line_unit_registers_test.sv
// top of the serial line unit testbench: clock, reset, stimulus and verdict
// depends on slu_pkg, slu_in_if, slu_out_if, the block and its checker

module serial_line_unit_registers_test;
  import slu_pkg::*;

  // the action code the block leaves unused; it must do nothing at all
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned RANDOM_BEATS = 900;
  // long receiver hold-off, enough for the block to fill both stages
  localparam int unsigned HOLD_CYCLES  = 300;
  // cycles after the last result, before the verdict
  localparam int unsigned DRAIN_CYCLES = 20;
  // worst case is every one of roughly 925 beats meeting the largest sender gap
  // and receiver stall, plus the hold-off, taken several times over
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic clk_i;
  logic rst_ni;

  slu_in_if  in_ch  ();
  slu_out_if out_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count;

  // set by the stimulus once, cleared by the receiver after its hold-off
  bit hold_req;
  // beats taken by the receiver, used to pick a stretch without stalls
  int unsigned results_taken;

  serial_line_unit_registers u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  serial_line_unit_registers_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_beat_i     (in_ch),
    .out_beat_i    (out_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // idle cycles in front of a beat; calm stretches send back to back,
  // otherwise half the beats come at once and the rest after a random gap
  function automatic int unsigned sender_gap(input bit calm);
    if (calm || $urandom_range(1, 0) == 0)
      return 0;
    return $urandom_range(14, 0);
  endfunction

  // random access or tick; mostly register-aligned offsets so that the
  // registers really move, a few odd ones for bus errors, rare unused action
  function automatic slu_in_t random_beat();
    slu_in_t b;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 35)
      b.action = ACT_POLL;
    else if (pick < 65)
      b.action = ACT_READ;
    else if (pick < 96)
      b.action = ACT_WRITE;
    else
      b.action = ACT_UNUSED;
    if ($urandom_range(9, 0) == 0)
      b.reg_offset = 3'($urandom_range(7, 0));
    else
      b.reg_offset = {2'($urandom_range(3, 0)), 1'b0};
    b.write_data = 16'($urandom);
    b.rx_valid   = 1'($urandom);
    b.rx_char    = 8'($urandom);
    return b;
  endfunction

  // offer one beat after the given gap and hold it until the block takes it;
  // valid gets one nonblocking write per edge, so back-to-back beats are clean
  task automatic offer_beat(input slu_in_t b, input int unsigned gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= b.action;
    in_ch.reg_offset <= b.reg_offset;
    in_ch.write_data <= b.write_data;
    in_ch.rx_valid   <= b.rx_valid;
    in_ch.rx_char    <= b.rx_char;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // receiver: per beat a random stall, one long hold-off on request, and a
  // stretch of beats taken with ready held high
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (results_taken >= 400 && results_taken < 550)
        stall = 0;
      else
        stall = $urandom_range(14, 0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      results_taken++;
    end
  end

  // sender: reset, directed accesses, random accesses, then the verdict
  initial begin
    int unsigned idx;
    bit calm;

    hold_req         = 1'b0;
    results_taken    = 0;
    cycle_count      = 0;
    rst_ni           = 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_POLL;
    in_ch.reg_offset <= OFF_RX_CSR;
    in_ch.write_data <= 16'h0000;
    in_ch.rx_valid   <= 1'b0;
    in_ch.rx_char    <= 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every register straight out of reset, the rx buffer read with done low
    offer_beat(slu_in_t'{ACT_READ, OFF_RX_CSR, 16'hffff, 1'b1, 8'hff}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_READ, OFF_RX_BUF, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_READ, OFF_TX_CSR, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_READ, OFF_TX_BUF, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    // odd offsets trap on read and on write and change nothing
    offer_beat(slu_in_t'{ACT_READ,  3'd1, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_READ,  3'd7, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_WRITE, 3'd3, 16'hffff, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_WRITE, 3'd5, 16'hffff, 1'b0, 8'h00}, sender_gap(0));
    // rx status write of all ones keeps done low, sets the enable
    offer_beat(slu_in_t'{ACT_WRITE, OFF_RX_CSR, 16'hffff, 1'b0, 8'h00}, sender_gap(0));
    // character arrives with interrupts on: irq, top bit dropped
    offer_beat(slu_in_t'{ACT_POLL, OFF_RX_CSR, 16'h0000, 1'b1, 8'hff}, sender_gap(0));
    // second character while done is still set is lost
    offer_beat(slu_in_t'{ACT_POLL, OFF_RX_CSR, 16'h0000, 1'b1, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_READ, OFF_RX_BUF, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    // rx buffer writes are ignored; disable rx interrupts and take a char
    offer_beat(slu_in_t'{ACT_WRITE, OFF_RX_BUF, 16'hffff, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_WRITE, OFF_RX_CSR, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_POLL, OFF_RX_CSR, 16'h0000, 1'b1, 8'h5a}, sender_gap(0));
    // enabling tx interrupts while idle arms the one-shot; the first poll
    // delivers it, the second is quiet
    offer_beat(slu_in_t'{ACT_WRITE, OFF_TX_CSR, 16'hffff, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_POLL, OFF_RX_CSR, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_POLL, OFF_RX_CSR, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    // rewrite after delivery only returns the phase to off, the next write arms it
    offer_beat(slu_in_t'{ACT_WRITE, OFF_TX_CSR, 16'h0040, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_WRITE, OFF_TX_CSR, 16'h0040, 1'b0, 8'h00}, sender_gap(0));
    // a transmitted NUL still counts as pending; poll completes it with irq
    offer_beat(slu_in_t'{ACT_WRITE, OFF_TX_BUF, 16'hff80, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_READ, OFF_TX_BUF, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_READ, OFF_TX_CSR, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_POLL, OFF_RX_CSR, 16'h0000, 1'b0, 8'h00}, sender_gap(0));
    offer_beat(slu_in_t'{ACT_WRITE, OFF_TX_BUF, 16'h007f, 1'b0, 8'h00}, sender_gap(0));
    // unused action with every field high must leave no trace
    offer_beat(slu_in_t'{ACT_UNUSED, 3'd7, 16'hffff, 1'b1, 8'hff}, sender_gap(0));

    // random part; the first beats go back to back while the receiver sits
    // in its long hold-off, so both stages fill and in ready drops
    hold_req = 1'b1;
    for (idx = 0; idx < RANDOM_BEATS; idx++) begin
      calm = (idx < 100) || (idx >= 600 && idx < 700);
      offer_beat(random_beat(), sender_gap(calm));
    end
    in_ch.valid <= 1'b0;

    // sample the checker away from the clock edge to stay clear of races
    do @(negedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
design/slu_pkg.sv
design/slu_in_if.sv
design/slu_out_if.sv
design/serial_line_unit_registers.sv
tb/sv/serial_line_unit_registers_checker.sv
tb/sv/serial_line_unit_registers_test.sv
